// ----- hdl/dedf_pkg.sv -----
package dedf_pkg;

	localparam int FRAME_DEPTH_DEF = 64;

	localparam logic [7:0] TERM_BYTE   = 8'hFF;
	localparam logic [7:0] FRAME_COMP  = 8'h65;
	localparam logic [7:0] FRAME_PAGE  = 8'h66;
	localparam logic [7:0] FRAME_TOUCH = 8'h67;
	localparam logic [7:0] FRAME_TEXT  = 8'h72;
	localparam logic [7:0] FRAME_VALUE = 8'h73;

	// terminators that close a frame
	localparam logic [1:0] TERM_CLOSE_CNT = 2'd3;

	// first stored byte that holds a text character
	localparam int TEXT_FIRST = 3;

	typedef enum logic [2:0] {
		EV_COMP  = 3'd0,
		EV_PAGE  = 3'd1,
		EV_TOUCH = 3'd2,
		EV_TEXT  = 3'd3,
		EV_VALUE = 3'd4,
		EV_EMPTY = 3'd5
	} ev_kind_t;

	// closed frame handed from front to back; fb[k] is stored byte k+1
	typedef struct packed {
		ev_kind_t        kind;
		logic [5:0][7:0] fb;
		logic            ovf;
		logic            bank;
	} frame_desc_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [7:0]  page_id;
		logic [7:0]  object_id;
		logic [7:0]  event_byte;
		logic [15:0] touch_x;
		logic [15:0] touch_y;
		logic [31:0] number_value;
		logic [7:0]  text_char;
		logic        text_valid;
		logic        last;
		logic        overflow;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_CHAR
	} back_state_t;

endpackage

// ----- hdl/dedf_front.sv -----
module dedf_front #(
	parameter int FRAME_DEPTH = dedf_pkg::FRAME_DEPTH_DEF,
	localparam int AW = $clog2(FRAME_DEPTH),
	localparam int CW = $clog2(FRAME_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	// store write port, address is bank then entry
	output logic                  wr_en,
	output logic [AW:0]           wr_addr,
	output logic [7:0]            wr_data,
	// closed frame push
	output logic                  push,
	output dedf_pkg::frame_desc_t push_desc,
	output logic [CW-1:0]         push_len,
	input  logic                  q_full
);
	import dedf_pkg::*;

	logic [1:0]    term_cnt_q;
	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic          bank_q;
	logic [7:0]    hdr_q [7];

	logic accept, is_term, store_ok, close;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_term  = in_byte == TERM_BYTE;
	assign store_ok = fill_q < CW'(FRAME_DEPTH);
	assign close    = accept && is_term && (term_cnt_q == TERM_CLOSE_CNT - 2'd1);

	assign wr_en   = accept && !is_term && store_ok;
	assign wr_addr = {bank_q, fill_q[AW-1:0]};
	assign wr_data = in_byte;

	// classify the frame on its closing terminator
	always_comb begin
		push           = 1'b0;
		push_desc.kind = EV_COMP;
		push_desc.ovf  = ovf_q;
		push_desc.bank = bank_q;
		for (int k = 0; k < 6; k++)
			push_desc.fb[k] = hdr_q[k + 1];
		push_len = fill_q;
		if (close) begin
			unique case (hdr_q[0])
				FRAME_COMP: begin
					push_desc.kind = EV_COMP;
					push           = fill_q >= CW'(4);
				end
				FRAME_PAGE: begin
					push_desc.kind = EV_PAGE;
					push           = fill_q >= CW'(2);
				end
				FRAME_TOUCH: begin
					push_desc.kind = EV_TOUCH;
					push           = fill_q >= CW'(6);
				end
				FRAME_TEXT: begin
					push_desc.kind = (fill_q == CW'(TEXT_FIRST)) ? EV_EMPTY : EV_TEXT;
					push           = fill_q >= CW'(TEXT_FIRST);
				end
				FRAME_VALUE: begin
					push_desc.kind = EV_VALUE;
					push           = fill_q >= CW'(7);
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_cnt_q <= '0;
			fill_q     <= '0;
			ovf_q      <= 1'b0;
			bank_q     <= 1'b0;
		end else if (accept) begin
			if (close) begin
				term_cnt_q <= '0;
				fill_q     <= '0;
				ovf_q      <= 1'b0;
				if (push)
					bank_q <= ~bank_q;
			end else if (is_term) begin
				term_cnt_q <= term_cnt_q + 2'd1;
			end else if (store_ok) begin
				fill_q <= fill_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// header bytes kept in flops for the kind and the header fields of every frame
	always_ff @(posedge clk) begin
		for (int i = 0; i < 7; i++)
			if (wr_en && fill_q == CW'(i))
				hdr_q[i] <= in_byte;
	end

endmodule

// ----- hdl/dedf_queue.sv -----
module dedf_queue #(
	parameter int FRAME_DEPTH = dedf_pkg::FRAME_DEPTH_DEF,
	localparam int CW = $clog2(FRAME_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dedf_pkg::frame_desc_t push_desc,
	input  logic [CW-1:0]         push_len,
	input  logic                  pop,
	output dedf_pkg::frame_desc_t head_desc,
	output logic [CW-1:0]         head_len,
	output logic                  head_valid,
	output logic                  full
);
	import dedf_pkg::*;

	// two entries, one for each store bank
	frame_desc_t   desc_q [2];
	logic [CW-1:0] len_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign head_desc  = desc_q[rp_q];
	assign head_len   = len_q[rp_q];
	assign head_valid = cnt_q != 2'd0;
	assign full       = cnt_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			desc_q[wp_q] <= push_desc;
			len_q[wp_q]  <= push_len;
		end
	end

endmodule

// ----- hdl/dedf_back.sv -----
module dedf_back #(
	parameter int FRAME_DEPTH = dedf_pkg::FRAME_DEPTH_DEF,
	localparam int AW = $clog2(FRAME_DEPTH),
	localparam int CW = $clog2(FRAME_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [AW:0]           wr_addr,
	input  logic [7:0]            wr_data,
	input  dedf_pkg::frame_desc_t head_desc,
	input  logic [CW-1:0]         head_len,
	input  logic                  head_valid,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output dedf_pkg::result_t     res
);
	import dedf_pkg::*;

	// two banks of frame bytes, each bank padded to a power of two
	logic [7:0] mem [2 ** (AW + 1)];
	logic [7:0] rd_q;

	back_state_t st_q, st_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [7:0]    page_q;
	logic [15:0]   x_q, y_q;
	result_t       res_q, res_d;
	logic          valid_q;
	logic          load, out_free, upd_page, upd_xy, text_last;

	assign out_free  = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res       = res_q;
	assign text_last = (CW'(idx_q) + CW'(1)) == head_len;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[{head_desc.bank, idx_q}];
	end

	always_comb begin
		st_d     = st_q;
		idx_d    = idx_q;
		pop      = 1'b0;
		load     = 1'b0;
		upd_page = 1'b0;
		upd_xy   = 1'b0;

		res_d.kind         = head_desc.kind;
		res_d.page_id      = head_desc.fb[0];
		res_d.object_id    = head_desc.fb[1];
		res_d.event_byte   = '0;
		res_d.touch_x      = x_q;
		res_d.touch_y      = y_q;
		res_d.number_value = '0;
		res_d.text_char    = '0;
		res_d.text_valid   = 1'b0;
		res_d.last         = 1'b1;
		res_d.overflow     = head_desc.ovf;

		unique case (head_desc.kind)
			EV_COMP: res_d.event_byte = head_desc.fb[2];
			EV_PAGE: begin
				res_d.object_id = '0;
				upd_page        = 1'b1;
			end
			EV_TOUCH: begin
				res_d.page_id    = page_q;
				res_d.object_id  = '0;
				res_d.event_byte = head_desc.fb[4];
				res_d.touch_x    = {head_desc.fb[0], head_desc.fb[1]};
				res_d.touch_y    = {head_desc.fb[2], head_desc.fb[3]};
				upd_xy           = 1'b1;
			end
			EV_VALUE: res_d.number_value = {head_desc.fb[5], head_desc.fb[4],
				head_desc.fb[3], head_desc.fb[2]};
			EV_TEXT: begin
				res_d.text_char  = rd_q;
				res_d.text_valid = 1'b1;
				res_d.last       = text_last;
			end
			EV_EMPTY: ;
			default: ;
		endcase

		unique case (st_q)
			BK_IDLE: begin
				if (head_valid && out_free) begin
					if (head_desc.kind == EV_TEXT) begin
						idx_d = AW'(TEXT_FIRST);
						st_d  = BK_READ;
					end else begin
						load = 1'b1;
						pop  = 1'b1;
					end
				end
			end
			BK_READ: st_d = BK_CHAR;
			BK_CHAR: begin
				if (out_free) begin
					load = 1'b1;
					if (text_last) begin
						pop  = 1'b1;
						st_d = BK_IDLE;
					end else begin
						idx_d = idx_q + AW'(1);
						st_d  = BK_READ;
					end
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BK_IDLE;
			idx_q   <= '0;
			valid_q <= 1'b0;
			page_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
			if (load)
				valid_q <= 1'b1;
			else if (res_ready)
				valid_q <= 1'b0;
			// state effects only on single-result frames, taken once at load
			if (load && st_q == BK_IDLE) begin
				if (upd_page)
					page_q <= head_desc.fb[0];
				if (upd_xy) begin
					x_q <= res_d.touch_x;
					y_q <= res_d.touch_y;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_d;
	end

endmodule

// ----- hdl/display_event_frame_decoder_unit.sv -----
// Decodes display-link bytes into event words. One byte is taken per cycle;
// 0xFF bytes are terminators and the third one closes the frame. A closed
// frame that gives results moves into a two-entry queue, and the frame
// store has two banks, so the next frame can be received while the back
// end still emits the previous one; input stalls only when two closed
// frames are waiting. The back end puts out a single-result frame straight
// from the queue head; a text frame starts in the idle state and then
// passes the read and char states for each character, as the frame store
// is read through a register. Frames too short for their kind, empty and
// unknown frames give no word. Bytes past FRAME_DEPTH are dropped and
// reported in the overflow bit of the frame's words.
module display_event_frame_decoder_unit #(
	parameter int FRAME_DEPTH = dedf_pkg::FRAME_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] page_id, [15:8] object_id, [23:16] event_byte, [39:24] touch_x,
	// [55:40] touch_y, [87:56] number_value, [95:88] text_char, [96] overflow
	output logic [103:0] m_axis_tdata,
	output logic [3:0]   m_axis_tuser,  // [2:0] event_kind, [3] text_valid
	output logic         m_axis_tlast
);
	import dedf_pkg::*;

	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int CW = $clog2(FRAME_DEPTH + 1);

	logic          wr_en;
	logic [AW:0]   wr_addr;
	logic [7:0]    wr_data;
	logic          push, pop, q_full, head_valid;
	frame_desc_t   push_desc, head_desc;
	logic [CW-1:0] push_len, head_len;
	result_t       res;

	dedf_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.push      (push),
		.push_desc (push_desc),
		.push_len  (push_len),
		.q_full    (q_full)
	);

	dedf_queue #(.FRAME_DEPTH(FRAME_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.push_len   (push_len),
		.pop        (pop),
		.head_desc  (head_desc),
		.head_len   (head_len),
		.head_valid (head_valid),
		.full       (q_full)
	);

	dedf_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.head_desc  (head_desc),
		.head_len   (head_len),
		.head_valid (head_valid),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	assign m_axis_tdata = {7'd0, res.overflow, res.text_char, res.number_value,
		res.touch_y, res.touch_x, res.event_byte, res.object_id, res.page_id};
	assign m_axis_tuser = {res.text_valid, res.kind};
	assign m_axis_tlast = res.last;

	// the bank being filled is never the one the back end reads
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && head_valid |-> wr_addr[AW] != head_desc.bank)
		else $error("frame store bank collision");

	// text flag and kind agree on every word
	a_text_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.text_valid == (res.kind == EV_TEXT)))
		else $error("text flag does not match kind");

	// every frame except text gives exactly one word
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.kind != EV_TEXT |-> m_axis_tlast)
		else $error("single-word frame without last");

endmodule

// ----- tb/dedf_event_checker.sv -----
module dedf_event_checker #(
	parameter int FRAME_DEPTH = dedf_pkg::FRAME_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [103:0] m_axis_tdata,
	input  logic [3:0]   m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           fail_count,
	output int           words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import dedf_pkg::*;

	// shortest stored frame that each kind reads from
	localparam int LEN_COMP  = 4;
	localparam int LEN_PAGE  = 2;
	localparam int LEN_TOUCH = 6;
	localparam int LEN_TEXT  = 3;
	localparam int LEN_VALUE = 7;

	int          term_seen;
	logic [7:0]  frame_bytes [FRAME_DEPTH];
	int          frame_fill;
	logic        dropped;
	logic [7:0]  page_now;
	logic [15:0] x_now;
	logic [15:0] y_now;

	result_t     expected_words [$];
	int          errors;

	function automatic result_t make_word(ev_kind_t kind, logic [7:0] pg, logic [7:0] obj,
			logic [7:0] ev, logic [31:0] num, logic [7:0] ch, logic valid, logic lst);
		result_t w;
		w.kind         = kind;
		w.page_id      = pg;
		w.object_id    = obj;
		w.event_byte   = ev;
		w.touch_x      = x_now;
		w.touch_y      = y_now;
		w.number_value = num;
		w.text_char    = ch;
		w.text_valid   = valid;
		w.last         = lst;
		w.overflow     = dropped;
		return w;
	endfunction

	task automatic queue_word(input result_t w);
		expected_words.insert(expected_words.size(), w);
	endtask

	// the third terminator closes the frame and decides its words
	task automatic decode_byte(input logic [7:0] b);
		int i;
		logic [31:0] v;
		if (b != TERM_BYTE) begin
			if (frame_fill < FRAME_DEPTH) begin
				frame_bytes[frame_fill] = b;
				frame_fill++;
			end else begin
				dropped = 1'b1;
			end
			return;
		end
		term_seen++;
		if (term_seen < TERM_CLOSE_CNT)
			return;
		if (frame_fill > 0) begin
			case (frame_bytes[0])
				FRAME_COMP: begin
					if (frame_fill >= LEN_COMP)
						queue_word(make_word(EV_COMP, frame_bytes[1],
							frame_bytes[2], frame_bytes[3], '0, '0, 1'b0, 1'b1));
				end
				FRAME_PAGE: begin
					if (frame_fill >= LEN_PAGE) begin
						page_now = frame_bytes[1];
						queue_word(make_word(EV_PAGE, page_now, '0, '0,
							'0, '0, 1'b0, 1'b1));
					end
				end
				FRAME_TOUCH: begin
					if (frame_fill >= LEN_TOUCH) begin
						x_now = {frame_bytes[1], frame_bytes[2]};
						y_now = {frame_bytes[3], frame_bytes[4]};
						queue_word(make_word(EV_TOUCH, page_now, '0,
							frame_bytes[5], '0, '0, 1'b0, 1'b1));
					end
				end
				FRAME_TEXT: begin
					if (frame_fill == LEN_TEXT) begin
						queue_word(make_word(EV_EMPTY, frame_bytes[1],
							frame_bytes[2], '0, '0, '0, 1'b0, 1'b1));
					end else if (frame_fill > LEN_TEXT) begin
						for (i = TEXT_FIRST; i < frame_fill; i++)
							queue_word(make_word(EV_TEXT, frame_bytes[1],
								frame_bytes[2], '0, '0, frame_bytes[i], 1'b1,
								i + 1 == frame_fill));
					end
				end
				FRAME_VALUE: begin
					if (frame_fill >= LEN_VALUE) begin
						v = {frame_bytes[6], frame_bytes[5], frame_bytes[4], frame_bytes[3]};
						queue_word(make_word(EV_VALUE, frame_bytes[1],
							frame_bytes[2], '0, v, '0, 1'b0, 1'b1));
					end
				end
				default: ;
			endcase
		end
		term_seen  = 0;
		frame_fill = 0;
		dropped    = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			term_seen  = 0;
			frame_fill = 0;
			dropped    = 1'b0;
			page_now   = '0;
			x_now      = '0;
			y_now      = '0;
			errors     = 0;
			expected_words.delete();
			fail_count    <= 0;
			words_pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: word with nothing expected, actual tuser %h tdata %h last %b",
						$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					want = expected_words.pop_front();
					check_field("event_kind", 32'(want.kind), 32'(m_axis_tuser[2:0]));
					check_field("page_id", 32'(want.page_id), 32'(m_axis_tdata[7:0]));
					check_field("object_id", 32'(want.object_id), 32'(m_axis_tdata[15:8]));
					check_field("event_byte", 32'(want.event_byte),
						32'(m_axis_tdata[23:16]));
					check_field("touch_x", 32'(want.touch_x), 32'(m_axis_tdata[39:24]));
					check_field("touch_y", 32'(want.touch_y), 32'(m_axis_tdata[55:40]));
					check_field("number_value", want.number_value, m_axis_tdata[87:56]);
					check_field("text_char", 32'(want.text_char), 32'(m_axis_tdata[95:88]));
					check_field("overflow", 32'(want.overflow), 32'(m_axis_tdata[96]));
					check_field("text_valid", 32'(want.text_valid), 32'(m_axis_tuser[3]));
					check_field("last", 32'(want.last), 32'(m_axis_tlast));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata);
			fail_count    <= errors;
			words_pending <= expected_words.size();
		end
	end

endmodule

// ----- tb/display_event_frame_decoder_unit_tb.sv -----
module display_event_frame_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dedf_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 40;
	localparam int BYTES_TOTAL = 450;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic [3:0]   m_axis_tuser;
	logic         m_axis_tlast;

	int fail_count;
	int words_pending;
	int send_idle = 38;
	int recv_idle = 65;
	int bytes_sent = 0;
	int stall_cycles = 0;

	display_event_frame_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	dedf_event_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("display_event_frame_decoder_unit: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// kind byte, len-1 random body bytes, then the closing terminators
	task automatic send_frame(input logic [7:0] kind, input int len);
		int i;
		send_byte(kind);
		for (i = 1; i < len; i++)
			send_byte(8'($urandom_range(254)));
		repeat (3) send_byte(TERM_BYTE);
	endtask

	task automatic send_random_frame();
		logic [7:0] kinds [5];
		int         min_len [5];
		int         pick;
		int         sel;
		int         n;
		kinds   = '{FRAME_COMP, FRAME_PAGE, FRAME_TOUCH, FRAME_TEXT, FRAME_VALUE};
		min_len = '{4, 2, 6, 3, 7};
		pick = $urandom_range(99);
		sel  = $urandom_range(4);
		if (pick < 5) begin
			// around the store depth, mostly past it
			send_frame(kinds[sel], FRAME_DEPTH_DEF + $urandom_range(6));
		end else if (pick < 78) begin
			if (kinds[sel] == FRAME_TEXT)
				send_frame(FRAME_TEXT, 3 + $urandom_range(12));
			else
				send_frame(kinds[sel], min_len[sel] + $urandom_range(3));
		end else if (pick < 86) begin
			send_frame(kinds[sel], $urandom_range(min_len[sel] - 1, 1));
		end else if (pick < 92) begin
			send_frame(8'($urandom_range(254)), 1 + $urandom_range(7));
		end else begin
			// loose bytes with stray terminators
			n = $urandom_range(8, 1);
			repeat (n) begin
				if ($urandom_range(2) == 0)
					send_byte(TERM_BYTE);
				else
					send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [7:0] directed [] = '{
			FRAME_PAGE, 8'hFE, TERM_BYTE, TERM_BYTE, TERM_BYTE,
			FRAME_TOUCH, 8'hFE, 8'hFE, 8'h00, 8'h00, 8'h01, TERM_BYTE, TERM_BYTE, TERM_BYTE,
			FRAME_COMP, 8'h00, 8'hFE, 8'h01, TERM_BYTE, TERM_BYTE, TERM_BYTE,
			FRAME_TEXT, 8'h01, 8'h02, 8'h41, 8'h42, TERM_BYTE, TERM_BYTE, TERM_BYTE,
			FRAME_TEXT, 8'h03, 8'h04, TERM_BYTE, TERM_BYTE, TERM_BYTE,
			FRAME_VALUE, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h80,
			TERM_BYTE, TERM_BYTE, TERM_BYTE,
			FRAME_VALUE, 8'hFE, 8'h00, 8'hFE, 8'hFE, 8'hFE, 8'h7F, 8'h11,
			TERM_BYTE, TERM_BYTE, TERM_BYTE,
			FRAME_TOUCH, 8'h01, 8'h02, TERM_BYTE, TERM_BYTE, TERM_BYTE,
			TERM_BYTE, TERM_BYTE, TERM_BYTE,
			8'h00, TERM_BYTE, TERM_BYTE, TERM_BYTE
		};
		int phase;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i]);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 38;
					recv_idle = 65;
				end
				1: begin
					send_idle = 65;
					recv_idle = 38;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			if (phase == 0)
				send_frame(FRAME_TEXT, FRAME_DEPTH_DEF + 3);
			while (bytes_sent < BYTES_TOTAL * (phase + 1) / 3)
				send_random_frame();
		end
		s_axis_tvalid <= 1'b0;

		// let the checker count the words of the last frame
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && words_pending == 0)
			$display("display_event_frame_decoder_unit: match");
		else
			$display("display_event_frame_decoder_unit: mismatch");
		$finish;
	end

endmodule
